### hdl/sstc_pkg.sv
// ----------------------------------------------------------------------------
// sstc_pkg: shared types and constants of the 3x3 sharpening stream
// Field widths, register indexes, filter modes, reset geometry and the
// result beat layout.
// ----------------------------------------------------------------------------
package sstc_pkg;

	localparam int PIX_W      = 8;
	localparam int ROW_W      = 16;
	localparam int COL_W      = 10;
	localparam int FWIDTH_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SLOT_N     = 3;
	localparam int SLOT_CNT_W = 2;

	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int RESET_WIDTH      = 640;
	localparam int RESET_HEIGHT     = 480;
	localparam int DIAG_OFFSET      = 100;
	localparam int PIX_MAX          = 255;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	localparam logic [1:0] MODE_LAPLACE  = 2'd0;
	localparam logic [1:0] MODE_HIGHPASS = 2'd1;
	localparam logic [1:0] MODE_DIAG     = 2'd2;

	typedef struct packed {
		logic row_ge1;
		logic row_ge2;
		logic col_ge1;
		logic col_ge2;
		logic col_last;
		logic row_last;
	} pos_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             last_of_item;
		logic             frame_done;
	} result_t;

endpackage

### hdl/sstc_if.sv
// ----------------------------------------------------------------------------
// sstc_if: stream and configuration channels of the sharpening stream
// Pixel input, result output and register write channels, each a
// valid/ready pair with its payload.
// ----------------------------------------------------------------------------
interface sstc_pix_if;
	import sstc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sstc_res_if;
	import sstc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic             last_of_item;
	logic             frame_done;

	modport source (output valid, output pixel_out, output out_row, output out_col,
		output last_of_item, output frame_done, input ready);
	modport sink   (input valid, input pixel_out, input out_row, input out_col,
		input last_of_item, input frame_done, output ready);
endinterface

interface sstc_cfg_if;
	import sstc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/sstc_line_store.sv
// ----------------------------------------------------------------------------
// sstc_line_store: two previous rows, one column pair per entry
// Upper byte holds the older row, lower byte the newer row. Read data is
// registered; the write of a column follows its read.
// ----------------------------------------------------------------------------
module sstc_line_store #(
	parameter int MAX_WIDTH = sstc_pkg::DEF_MAX_WIDTH,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [CW-1:0]             rd_addr,
	input  logic                      wr_en,
	input  logic [CW-1:0]             wr_addr,
	input  logic [2*sstc_pkg::PIX_W-1:0] wr_data,
	output logic [2*sstc_pkg::PIX_W-1:0] rd_data
);
	import sstc_pkg::*;

	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/sstc_window.sv
// ----------------------------------------------------------------------------
// sstc_window: 3x3 neighbourhood, filter and result slot builder
// Holds the two older window columns, forms the new column from the line
// store and the pixel, filters the centre and orders the results of a pixel.
// ----------------------------------------------------------------------------
module sstc_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [1:0]                   mode,
	input  sstc_pkg::pos_t               pos,
	input  logic [sstc_pkg::ROW_W-1:0]   row,
	input  logic [sstc_pkg::COL_W-1:0]   col,
	input  logic [sstc_pkg::PIX_W-1:0]   top_new,
	input  logic [sstc_pkg::PIX_W-1:0]   mid_new,
	input  logic [sstc_pkg::PIX_W-1:0]   pix,
	output sstc_pkg::result_t            slots [sstc_pkg::SLOT_N],
	output logic [sstc_pkg::SLOT_CNT_W-1:0] slot_cnt
);
	import sstc_pkg::*;

	logic [PIX_W-1:0] win_q [3][2];

	logic [PIX_W-1:0] ul, up, ur, lf, cc, rt, dl, dn, dr;
	logic [PIX_W+1:0] sum4, c4, mag0;
	logic [PIX_W+3:0] c9, sum8, mag1;
	logic [PIX_W-1:0] d_diag, d_vert;
	logic [PIX_W+1:0] mag2;
	logic [PIX_W+3:0] mag;
	logic [PIX_W-1:0] filt;
	logic             has_a, has_b, has_c;
	result_t          res_a, res_b, res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= '0;
				win_q[r][1] <= '0;
			end
		end else if (advance) begin
			win_q[0][0] <= win_q[0][1];
			win_q[1][0] <= win_q[1][1];
			win_q[2][0] <= win_q[2][1];
			win_q[0][1] <= top_new;
			win_q[1][1] <= mid_new;
			win_q[2][1] <= pix;
		end
	end

	assign ul = win_q[0][0];
	assign up = win_q[0][1];
	assign ur = top_new;
	assign lf = win_q[1][0];
	assign cc = win_q[1][1];
	assign rt = mid_new;
	assign dl = win_q[2][0];
	assign dn = win_q[2][1];
	assign dr = pix;

	always_comb begin
		sum4 = 10'(up) + 10'(lf) + 10'(rt) + 10'(dn);
		c4   = {cc, 2'b00};
		mag0 = (sum4 >= c4) ? sum4 - c4 : c4 - sum4;

		c9   = 12'({cc, 3'b000}) + 12'(cc);
		sum8 = 12'(ul) + 12'(up) + 12'(ur) + 12'(lf) + 12'(rt) + 12'(dl) + 12'(dn) + 12'(dr);
		mag1 = (c9 >= sum8) ? c9 - sum8 : sum8 - c9;

		d_diag = (ul >= cc) ? ul - cc : cc - ul;
		d_vert = (up >= lf) ? up - lf : lf - up;
		mag2   = 10'(d_diag) + 10'(d_vert) + 10'(DIAG_OFFSET);

		case (mode)
			MODE_LAPLACE:  mag = 12'(mag0);
			MODE_HIGHPASS: mag = mag1;
			MODE_DIAG:     mag = 12'(mag2);
			default:       mag = 12'(mag0);
		endcase
		filt = (mag > 12'(PIX_MAX)) ? PIX_W'(PIX_MAX) : mag[PIX_W-1:0];
	end

	always_comb begin
		logic [SLOT_CNT_W-1:0] n;

		has_a = pos.row_ge1 & pos.col_ge1;
		has_b = pos.row_ge1 & pos.col_last;
		has_c = pos.row_ge1 & pos.row_last;

		res_a.pixel_out    = (pos.row_ge2 && pos.col_ge2) ? filt : cc;
		res_a.out_row      = row - ROW_W'(1);
		res_a.out_col      = col - COL_W'(1);
		res_a.last_of_item = 1'b0;
		res_a.frame_done   = 1'b0;

		res_b.pixel_out    = mid_new;
		res_b.out_row      = row - ROW_W'(1);
		res_b.out_col      = col;
		res_b.last_of_item = 1'b0;
		res_b.frame_done   = 1'b0;

		res_c.pixel_out    = pix;
		res_c.out_row      = row;
		res_c.out_col      = col;
		res_c.last_of_item = 1'b0;
		res_c.frame_done   = 1'b0;

		for (int k = 0; k < SLOT_N; k++) begin
			slots[k] = '0;
		end
		n = '0;
		if (has_a) begin
			slots[n] = res_a;
			n = n + 2'd1;
		end
		if (has_b) begin
			slots[n] = res_b;
			n = n + 2'd1;
		end
		if (has_c) begin
			slots[n] = res_c;
			n = n + 2'd1;
		end
		if (n != '0) begin
			slots[2'(n - 2'd1)].last_of_item = 1'b1;
			slots[2'(n - 2'd1)].frame_done   = pos.row_last & pos.col_last;
		end
		slot_cnt = n;
	end

endmodule

### hdl/sstc_result_queue.sv
// ----------------------------------------------------------------------------
// sstc_result_queue: result register for up to three beats of one pixel
// Loads the ordered results of a pixel and hands them out one beat at a
// time; reports room when it is empty or its last beat is taken this cycle.
// ----------------------------------------------------------------------------
module sstc_result_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  sstc_pkg::result_t               slots [sstc_pkg::SLOT_N],
	input  logic [sstc_pkg::SLOT_CNT_W-1:0] slot_cnt,
	output logic                            room,
	sstc_res_if.source                      results
);
	import sstc_pkg::*;

	result_t               res_q [SLOT_N];
	logic [SLOT_CNT_W-1:0] cnt_q;
	logic [SLOT_CNT_W-1:0] ptr_q;
	result_t               head;
	logic                  beat;

	assign results.valid = (ptr_q != cnt_q);
	assign beat          = results.valid & results.ready;
	assign room          = (ptr_q == cnt_q) || ((ptr_q + 2'd1 == cnt_q) && results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (load) begin
			cnt_q <= slot_cnt;
			ptr_q <= '0;
		end else if (beat) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < SLOT_N; k++) begin
				res_q[k] <= slots[k];
			end
		end
	end

	always_comb begin
		case (ptr_q)
			2'd1:    head = res_q[1];
			2'd2:    head = res_q[2];
			default: head = res_q[0];
		endcase
	end

	assign results.pixel_out    = head.pixel_out;
	assign results.out_row      = head.out_row;
	assign results.out_col      = head.out_col;
	assign results.last_of_item = head.last_of_item;
	assign results.frame_done   = head.frame_done;

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= cnt_q)
		else $error("result pointer beyond loaded count");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> room)
		else $error("results loaded over undelivered beats");

	a_last_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.last_of_item) |-> (ptr_q + 2'd1 == cnt_q))
		else $error("last_of_item not on final beat of a pixel");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.frame_done) |-> results.last_of_item)
		else $error("frame_done without last_of_item");

endmodule

### hdl/sharpen_stencil_3x3_stream.sv
// ----------------------------------------------------------------------------
// sharpen_stencil_3x3_stream: 3x3 sharpening filter over a raster stream
// Top level: configuration registers, raster counters, input register and
// the line store, window and result queue around them.
// ----------------------------------------------------------------------------
// Usage:
//   pixels  : grey pixels in raster order, one per beat.
//   results : filtered pixels with row and column, one per beat; last_of_item
//             marks the final beat caused by a pixel, frame_done the final
//             beat of a frame.
//   cfg     : register writes (mode, frame width, frame height), always ready;
//             a geometry write restarts the frame at pixel (0,0). Write only
//             while the stream is idle.
// Path: input register, then result queue, then the results port.
// Throughput: one pixel per cycle without receiver stalls while each pixel
//   gives at most one beat; a pixel that gives k beats (row ends, last row)
//   holds the input for the single result port. First-row pixels give no beat.
// Reset: mode 0, 640 x 480 frame, counters and window cleared; the line
//   stores are not cleared and need no clearing pass.
// Stall: a stalled receiver holds the current beat; the next pixel that gives
//   a beat waits in the input register, then pixels.ready drops.
// ----------------------------------------------------------------------------
module sharpen_stencil_3x3_stream #(
	parameter int MAX_WIDTH = sstc_pkg::DEF_MAX_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	sstc_cfg_if.sink   cfg,
	sstc_pix_if.sink   pixels,
	sstc_res_if.source results
);
	import sstc_pkg::*;

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int EW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (EW > FWIDTH_W) ? EW : FWIDTH_W;

	function automatic logic [CW-1:0] eff_col_last(input logic [FWIDTH_W-1:0] fw);
		logic [CMPW-1:0] ext;
		ext = CMPW'(fw);
		if (ext < CMPW'(3)) begin
			return CW'(2);
		end else if (ext > CMPW'(MAX_WIDTH)) begin
			return CW'(MAX_WIDTH - 1);
		end
		return CW'(ext - CMPW'(1));
	endfunction

	function automatic logic [ROW_W-1:0] eff_row_last(input logic [ROW_W-1:0] fh);
		return (fh < ROW_W'(3)) ? ROW_W'(2) : fh - ROW_W'(1);
	endfunction

	logic [1:0]       mode_q;
	logic [CW-1:0]    col_last_q;
	logic [ROW_W-1:0] row_last_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [ROW_W-1:0] row_s1;
	logic [CW-1:0]    col_s1;
	pos_t             pos_s1;

	logic                  accept;
	logic                  advance;
	logic                  room;
	logic [2*PIX_W-1:0]    rd_data;
	result_t               slots [SLOT_N];
	logic [SLOT_CNT_W-1:0] slot_cnt;

	assign cfg.ready    = 1'b1;
	assign advance      = valid_s1 & ((slot_cnt == '0) | room);
	assign pixels.ready = ~valid_s1 | advance;
	assign accept       = pixels.valid & pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_LAPLACE;
			col_last_q <= eff_col_last(FWIDTH_W'(RESET_WIDTH));
			row_last_q <= eff_row_last(ROW_W'(RESET_HEIGHT));
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MODE:   mode_q <= cfg.data[1:0];
				CFG_WIDTH: begin
					col_last_q <= eff_col_last(cfg.data[FWIDTH_W-1:0]);
					col_q      <= '0;
					row_q      <= '0;
				end
				CFG_HEIGHT: begin
					row_last_q <= eff_row_last(cfg.data);
					col_q      <= '0;
					row_q      <= '0;
				end
				default: ;
			endcase
		end else if (accept) begin
			if (col_q == col_last_q) begin
				col_q <= '0;
				row_q <= (row_q == row_last_q) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1          <= pixels.pixel_in;
			row_s1          <= row_q;
			col_s1          <= col_q;
			pos_s1.row_ge1  <= (row_q != '0);
			pos_s1.row_ge2  <= (row_q >= ROW_W'(2));
			pos_s1.col_ge1  <= (col_q != '0);
			pos_s1.col_ge2  <= (col_q >= CW'(2));
			pos_s1.col_last <= (col_q == col_last_q);
			pos_s1.row_last <= (row_q == row_last_q);
		end
	end

	sstc_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.wr_en   (advance),
		.wr_addr (col_s1),
		.wr_data ({rd_data[PIX_W-1:0], pix_s1}),
		.rd_data (rd_data)
	);

	sstc_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.mode     (mode_q),
		.pos      (pos_s1),
		.row      (row_s1),
		.col      (COL_W'(col_s1)),
		.top_new  (rd_data[2*PIX_W-1:PIX_W]),
		.mid_new  (rd_data[PIX_W-1:0]),
		.pix      (pix_s1),
		.slots    (slots),
		.slot_cnt (slot_cnt)
	);

	sstc_result_queue u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && (slot_cnt != '0)),
		.slots    (slots),
		.slot_cnt (slot_cnt),
		.room     (room),
		.results  (results)
	);

endmodule
